[sv/lpd_pkg.sv]
// Shared types and constants for the length-prefix deframer.
// No dependencies; imported by lpd_parser, lpd_out_stage and length_prefix_deframer.
package lpd_pkg;

    localparam int MAX_FRAME_DEF = 2048;
    localparam int BYTE_W        = 8;
    localparam int FLEN_W        = 12;
    localparam int LEN_W         = 32;
    localparam int PREFIX_BYTES  = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic [FLEN_W-1:0]  frame_length;
    } result_t;

endpackage

[sv/lpd_parser.sv]
// Prefix gather / payload count state machine; one result per accepted beat at most.
// Depends on lpd_pkg.
module lpd_parser #(
    parameter int MAX_FRAME = lpd_pkg::MAX_FRAME_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       beat_accept,
    input  logic [lpd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       receive_enable,
    output logic                       res_valid,
    output lpd_pkg::result_t           res
);
    import lpd_pkg::*;

    localparam int CNT_W = (MAX_FRAME < 2) ? 1 : $clog2(MAX_FRAME + 1);
    localparam int IDX_W = $clog2(PREFIX_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);
    localparam logic [LEN_W-1:0] FLEN_MAX = LEN_W'((1 << FLEN_W) - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PREFIX_BYTES - 1);

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } phase_t;

    phase_t                                phase_reg, phase_next;
    logic [IDX_W-1:0]                      idx_reg, idx_next;
    logic [(PREFIX_BYTES-1)*BYTE_W-1:0]    pre_reg, pre_next;
    logic [CNT_W-1:0]                      len_reg, len_next;
    logic [CNT_W-1:0]                      cnt_reg, cnt_next;

    logic [LEN_W-1:0] full_len;
    logic [LEN_W-1:0] len_ext;
    logic [CNT_W-1:0] cnt_inc;

    // prefix is little-endian: earlier bytes shift down, last byte lands on top
    assign full_len = {rx_byte, pre_reg};
    assign len_ext  = LEN_W'(len_reg);
    assign cnt_inc  = cnt_reg + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        pre_next   = pre_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        res_valid  = 1'b0;
        res        = '{kind: KIND_PAYLOAD, data: '0, last: 1'b0, frame_length: '0};
        if (beat_accept) begin
            unique case (phase_reg)
                PH_PREFIX: begin
                    if (idx_reg != IDX_LAST) begin
                        pre_next = {rx_byte, pre_reg[(PREFIX_BYTES-1)*BYTE_W-1:BYTE_W]};
                        idx_next = idx_reg + 1'b1;
                    end else begin
                        idx_next = '0;
                        cnt_next = '0;
                        if (full_len > MAX_LEN) begin
                            phase_next       = PH_HALTED;
                            res_valid        = 1'b1;
                            res.kind         = KIND_ERROR;
                            res.frame_length = (full_len > FLEN_MAX) ?
                                               FLEN_MAX[FLEN_W-1:0] : full_len[FLEN_W-1:0];
                        end else if (full_len == '0) begin
                            res_valid = receive_enable;
                            res.kind  = KIND_EMPTY;
                            res.last  = 1'b1;
                        end else begin
                            phase_next = PH_PAYLOAD;
                            len_next   = full_len[CNT_W-1:0];
                        end
                    end
                end
                PH_PAYLOAD: begin
                    res_valid        = receive_enable;
                    res.data         = rx_byte;
                    res.frame_length = len_ext[FLEN_W-1:0];
                    if (cnt_inc >= len_reg) begin
                        phase_next = PH_PREFIX;
                        cnt_next   = '0;
                        res.last   = 1'b1;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_HALTED: begin
                    phase_next = PH_HALTED;
                end
                default: begin
                    phase_next = PH_HALTED;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
        pre_reg <= pre_next;
        len_reg <= len_next;
    end

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HALTED |=> phase_reg == PH_HALTED)
        else $error("halted state left without reset");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> cnt_reg < len_reg)
        else $error("payload count reached frame length");

    a_idx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_PREFIX |-> idx_reg == '0)
        else $error("prefix index nonzero outside prefix gather");

    a_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_ERROR |=> phase_reg == PH_HALTED)
        else $error("error result without halt");

endmodule

[sv/lpd_out_stage.sv]
// Result register with valid/ready toward the consumer.
// Depends on lpd_pkg.
module lpd_out_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       res_valid,
    input  lpd_pkg::result_t           res,
    output logic                       accept_ok,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [lpd_pkg::BYTE_W-1:0] m_data,
    output logic                       m_last,
    output logic [lpd_pkg::FLEN_W-1:0] m_frame_length
);
    import lpd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // upstream may step whenever this slot is empty or drains this cycle
    assign accept_ok = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept_ok) begin
            valid_reg <= res_valid;
        end
        if (accept_ok && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_kind         = res_reg.kind;
    assign m_data         = res_reg.data;
    assign m_last         = res_reg.last;
    assign m_frame_length = res_reg.frame_length;

endmodule

[sv/length_prefix_deframer.sv]
// Top level of the length-prefix deframer: config register, parser, result register.
// Depends on lpd_pkg, lpd_parser, lpd_out_stage.
//
//   channel   prefix  payload                                   direction
//   input     s_      rx_byte[7:0]                              in
//   result    m_      kind[1:0] data[7:0] last frame_length[11:0] out
//   config    cfg_    data (receive_enable)                     in
//
// One input beat per cycle while s_ready is high; result is valid the cycle after.
// s_ready is high while the result register is empty or being drained.
// A stalled m_ready holds s_ready low only when a result is waiting.
// Reset returns to prefix gather with receive disabled; an oversize length gives
// an error result, then halts the deframer (beats consumed, no results) until reset.
module length_prefix_deframer #(
    parameter int MAX_FRAME = lpd_pkg::MAX_FRAME_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [lpd_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [lpd_pkg::BYTE_W-1:0] m_data,
    output logic                       m_last,
    output logic [lpd_pkg::FLEN_W-1:0] m_frame_length,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data
);
    import lpd_pkg::*;

    logic    rx_en_reg;
    logic    accept_ok;
    logic    beat_accept;
    logic    res_valid;
    result_t res;

    assign cfg_ready   = 1'b1;
    assign s_ready     = accept_ok;
    assign beat_accept = s_valid && accept_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_en_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            rx_en_reg <= cfg_data;
        end
    end

    lpd_parser #(
        .MAX_FRAME(MAX_FRAME)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .beat_accept   (beat_accept),
        .rx_byte       (s_rx_byte),
        .receive_enable(rx_en_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    lpd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res           (res),
        .accept_ok     (accept_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data        (m_data),
        .m_last        (m_last),
        .m_frame_length(m_frame_length)
    );

endmodule
